// File: rtl/wfc_pkg.sv
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared types and constants of the wall and floor colour classifier.
// ----------------------------------------------------------------------------
package wfc_pkg;

   localparam int READING_WIDTH   = 12;
   localparam int BYTE_WIDTH      = 8;
   localparam int CHAN_WIDTH      = 6;
   localparam int SUM_WIDTH       = 16;
   localparam int LEVEL_WIDTH     = 8;
   localparam int PRODUCT_WIDTH   = SUM_WIDTH + LEVEL_WIDTH;
   localparam int WALL_WIDTH      = 4;
   localparam int COLOR_WIDTH     = 3;
   localparam int CELL_WIDTH      = WALL_WIDTH + COLOR_WIDTH;
   localparam int CSR_INDEX_WIDTH = 2;
   localparam int CSR_DATA_WIDTH  = 12;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WALL_LIMIT  = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TINT_LIMIT  = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_FULL_SCALE  = 2'd2;

   localparam logic [READING_WIDTH-1:0] WALL_LIMIT_RESET = 12'd150;
   localparam logic [LEVEL_WIDTH-1:0]   TINT_LIMIT_RESET = 8'd70;
   localparam logic [LEVEL_WIDTH-1:0]   FULL_SCALE_RESET = 8'd100;

   localparam logic KIND_SCAN  = 1'b0;
   localparam logic KIND_PIXEL = 1'b1;

   typedef struct packed {
      logic [READING_WIDTH-1:0] wall_limit;
      logic [LEVEL_WIDTH-1:0]   tint_limit;
      logic [LEVEL_WIDTH-1:0]   full_scale;
   } cfg_type;

   typedef struct packed {
      logic                  kind;
      logic [WALL_WIDTH-1:0] walls;
      logic [CHAN_WIDTH-1:0] red;
      logic [CHAN_WIDTH-1:0] green;
      logic [CHAN_WIDTH-1:0] blue;
      logic                  last;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   typedef enum logic [2:0] {
      BACK_IDLE,
      BACK_PEAK,
      BACK_MULT,
      BACK_WAIT,
      BACK_FINISH
   } back_state_type;

endpackage

// File: rtl/wfc_if.sv
// ----------------------------------------------------------------------------
// wfc request and response interfaces
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface wfc_req_if;
   import wfc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     req_type;
   logic [READING_WIDTH-1:0] front_left_reading;
   logic [READING_WIDTH-1:0] right_reading;
   logic [READING_WIDTH-1:0] back_right_reading;
   logic [READING_WIDTH-1:0] back_left_reading;
   logic [READING_WIDTH-1:0] left_reading;
   logic [READING_WIDTH-1:0] front_right_reading;
   logic [BYTE_WIDTH-1:0]    pixel_high_byte;
   logic [BYTE_WIDTH-1:0]    pixel_low_byte;
   logic                     last_pixel;

   modport source (
      output valid, req_type, front_left_reading, right_reading, back_right_reading,
             back_left_reading, left_reading, front_right_reading, pixel_high_byte,
             pixel_low_byte, last_pixel,
      input  ready
   );

   modport sink (
      input  valid, req_type, front_left_reading, right_reading, back_right_reading,
             back_left_reading, left_reading, front_right_reading, pixel_high_byte,
             pixel_low_byte, last_pixel,
      output ready
   );
endinterface

interface wfc_rsp_if;
   import wfc_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   result_kind;
   logic [CELL_WIDTH-1:0]  cell_res;
   logic [LEVEL_WIDTH-1:0] red_level;
   logic [LEVEL_WIDTH-1:0] green_level;
   logic [LEVEL_WIDTH-1:0] blue_level;

   modport source (
      output valid, result_kind, cell_res, red_level, green_level, blue_level,
      input  ready
   );

   modport sink (
      input  valid, result_kind, cell_res, red_level, green_level, blue_level,
      output ready
   );
endinterface

// File: rtl/wall_and_floor_color_classifier_top.sv
// ----------------------------------------------------------------------------
// wall_and_floor_color_classifier_top
// Classifies proximity scans into wall bits and colour lines into floor bits.
// ----------------------------------------------------------------------------
// A scan response is registered in the back part once its request has passed
// the queue; a line response is registered after the last pixel is scaled.
// Throughput: one request per cycle while the two-entry queue has room; the
// back part retires one scan or pixel per cycle while the response register is
// free, and a last pixel holds it while the shared divider makes three divisions.
// Reset clears the cell word and sums and restores the register defaults.
module wall_and_floor_color_classifier_top
   import wfc_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   wfc_req_if.sink                    req_ch,
   wfc_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   cfg_type          cfg_ff;
   queue_status_type queue_status;
   logic             push, pop;
   cmd_type          push_cmd, pop_cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wall_limit <= WALL_LIMIT_RESET;
         cfg_ff.tint_limit <= TINT_LIMIT_RESET;
         cfg_ff.full_scale <= FULL_SCALE_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_WALL_LIMIT: cfg_ff.wall_limit <= csr_wdata;
            CSR_TINT_LIMIT: cfg_ff.tint_limit <= csr_wdata[LEVEL_WIDTH-1:0];
            CSR_FULL_SCALE: cfg_ff.full_scale <= csr_wdata[LEVEL_WIDTH-1:0];
            default:        ;
         endcase
      end
   end

   wfc_front u_front (
      .req_ch       (req_ch),
      .wall_limit   (cfg_ff.wall_limit),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   wfc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .pop_cmd  (pop_cmd),
      .status   (queue_status)
   );

   wfc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .tint_limit   (cfg_ff.tint_limit),
      .full_scale   (cfg_ff.full_scale),
      .queue_status (queue_status),
      .pop_cmd      (pop_cmd),
      .pop          (pop),
      .rsp_ch       (rsp_ch)
   );

endmodule

// File: rtl/wfc_front.sv
// ----------------------------------------------------------------------------
// wfc_front
// Accepts requests, classifies proximity readings and unpacks RGB565 pixels.
// ----------------------------------------------------------------------------
module wfc_front
   import wfc_pkg::*;
(
   wfc_req_if.sink                  req_ch,
   input  logic [READING_WIDTH-1:0] wall_limit,
   input  queue_status_type         queue_status,
   output logic                     push,
   output cmd_type                  push_cmd
);

   logic ir1, ir3, ir4, ir5, ir6, ir8;

   assign ir1 = req_ch.front_left_reading  > wall_limit;
   assign ir3 = req_ch.right_reading       > wall_limit;
   assign ir4 = req_ch.back_right_reading  > wall_limit;
   assign ir5 = req_ch.back_left_reading   > wall_limit;
   assign ir6 = req_ch.left_reading        > wall_limit;
   assign ir8 = req_ch.front_right_reading > wall_limit;

   assign req_ch.ready = !queue_status.full;
   assign push         = req_ch.valid && !queue_status.full;

   always_comb begin
      push_cmd.kind  = req_ch.req_type;
      push_cmd.walls = {ir6, ir4 || ir5, ir3, ir1 || ir8};
      push_cmd.red   = {req_ch.pixel_high_byte[7:3], 1'b0};
      push_cmd.green = {req_ch.pixel_high_byte[2:0], req_ch.pixel_low_byte[7:5]};
      push_cmd.blue  = {req_ch.pixel_low_byte[4:0], 1'b0};
      push_cmd.last  = req_ch.last_pixel;
   end

endmodule

// File: rtl/wfc_queue.sv
// ----------------------------------------------------------------------------
// wfc_queue
// Short command queue between the front and back parts.
// ----------------------------------------------------------------------------
module wfc_queue
   import wfc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output cmd_type          pop_cmd,
   output queue_status_type status
);

   cmd_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;

   assign status.full  = count_ff == QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign status.valid = count_ff != '0;
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_WIDTH'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_WIDTH'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/wfc_div.sv
// ----------------------------------------------------------------------------
// wfc_div
// Restoring divider producing an eight-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module wfc_div
   import wfc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [PRODUCT_WIDTH-1:0] dividend,
   input  logic [SUM_WIDTH-1:0]     divisor,
   output logic                     done,
   output logic [LEVEL_WIDTH-1:0]   quotient
);

   localparam int STEP_WIDTH = $clog2(LEVEL_WIDTH);

   logic [PRODUCT_WIDTH-1:0] rem_ff, rem_in;
   logic [SUM_WIDTH-1:0]     divisor_ff;
   logic [STEP_WIDTH-1:0]    step_ff, step_in;
   logic [LEVEL_WIDTH-1:0]   quot_ff, quot_in;
   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [PRODUCT_WIDTH-1:0] shifted;
   logic                     fits;

   // The quotient never exceeds full scale, so eight trial subtractions suffice.
   assign shifted  = PRODUCT_WIDTH'(divisor_ff) << step_ff;
   assign fits     = rem_ff >= shifted;
   assign done     = done_ff;
   assign quotient = quot_ff;

   always_comb begin
      rem_in  = rem_ff;
      step_in = step_ff;
      quot_in = quot_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = dividend;
         step_in = STEP_WIDTH'(LEVEL_WIDTH - 1);
         quot_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in           = rem_ff - shifted;
            quot_in[step_ff] = 1'b1;
         end
         step_in = step_ff - STEP_WIDTH'(1);
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      step_ff <= step_in;
      quot_ff <= quot_in;
      if (start) begin
         divisor_ff <= divisor;
      end
   end

endmodule

// File: rtl/wfc_back.sv
// ----------------------------------------------------------------------------
// wfc_back
// Holds the cell word and colour sums, scales finished lines and drives
// the response register.
// ----------------------------------------------------------------------------
module wfc_back
   import wfc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [LEVEL_WIDTH-1:0] tint_limit,
   input  logic [LEVEL_WIDTH-1:0] full_scale,
   input  queue_status_type       queue_status,
   input  cmd_type                pop_cmd,
   output logic                   pop,
   wfc_rsp_if.source              rsp_ch
);

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   back_state_type state_ff, state_in;

   logic [WALL_WIDTH-1:0]  walls_ff;
   logic [COLOR_WIDTH-1:0] colors_ff, colors_in;
   logic [SUM_WIDTH-1:0]   red_sum_ff, green_sum_ff, blue_sum_ff;
   logic [SUM_WIDTH-1:0]   red_add, green_add, blue_add;
   logic [SUM_WIDTH-1:0]   peak_ff, peak_in;
   logic [1:0]             chan_ff;
   logic [LEVEL_WIDTH-1:0] red_level_ff, green_level_ff, blue_level_ff;
   logic [LEVEL_WIDTH-1:0] level_value;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_kind_ff;
   logic [CELL_WIDTH-1:0]  rsp_cell_ff;
   logic [LEVEL_WIDTH-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   logic                     out_free;
   logic                     take_scan, take_pixel, start_div, store_level, finish;
   logic [SUM_WIDTH-1:0]     sel_sum;
   logic [PRODUCT_WIDTH-1:0] product;
   logic                     div_done;
   logic [LEVEL_WIDTH-1:0]   div_quot;

   function automatic logic [SUM_WIDTH-1:0] sat_add(
      input logic [SUM_WIDTH-1:0]  acc,
      input logic [CHAN_WIDTH-1:0] value
   );
      logic [SUM_WIDTH:0] total;
      total = {1'b0, acc} + (SUM_WIDTH + 1)'(value);
      return total[SUM_WIDTH] ? {SUM_WIDTH{1'b1}} : total[SUM_WIDTH-1:0];
   endfunction

   assign out_free  = !rsp_valid_ff || rsp_ch.ready;
   assign red_add   = sat_add(red_sum_ff,   pop_cmd.red);
   assign green_add = sat_add(green_sum_ff, pop_cmd.green);
   assign blue_add  = sat_add(blue_sum_ff,  pop_cmd.blue);

   always_comb begin
      if (red_sum_ff >= green_sum_ff && red_sum_ff >= blue_sum_ff) begin
         peak_in = red_sum_ff;
      end else if (green_sum_ff >= blue_sum_ff) begin
         peak_in = green_sum_ff;
      end else begin
         peak_in = blue_sum_ff;
      end
   end

   always_comb begin
      unique case (chan_ff)
         CH_RED:   sel_sum = red_sum_ff;
         CH_GREEN: sel_sum = green_sum_ff;
         default:  sel_sum = blue_sum_ff;
      endcase
   end

   assign product     = PRODUCT_WIDTH'(sel_sum) * PRODUCT_WIDTH'(full_scale);
   assign level_value = (peak_ff == '0) ? '0 : div_quot;
   assign colors_in   = {red_level_ff > tint_limit, green_level_ff > tint_limit,
                         blue_level_ff > tint_limit};

   wfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_div),
      .dividend (product),
      .divisor  (peak_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BACK_IDLE: begin
            if (queue_status.valid && out_free && pop_cmd.kind == KIND_PIXEL &&
                pop_cmd.last) begin
               state_in = BACK_PEAK;
            end
         end
         BACK_PEAK: state_in = BACK_MULT;
         BACK_MULT: state_in = BACK_WAIT;
         BACK_WAIT: begin
            if (div_done) begin
               state_in = (chan_ff == CH_BLUE) ? BACK_FINISH : BACK_MULT;
            end
         end
         BACK_FINISH: state_in = BACK_IDLE;
         default:     state_in = BACK_IDLE;
      endcase
   end

   always_comb begin
      pop         = 1'b0;
      take_scan   = 1'b0;
      take_pixel  = 1'b0;
      start_div   = 1'b0;
      store_level = 1'b0;
      finish      = 1'b0;
      unique case (state_ff)
         BACK_IDLE: begin
            if (queue_status.valid && out_free) begin
               pop        = 1'b1;
               take_scan  = pop_cmd.kind == KIND_SCAN;
               take_pixel = pop_cmd.kind == KIND_PIXEL;
            end
         end
         BACK_PEAK:   ;
         BACK_MULT:   start_div   = 1'b1;
         BACK_WAIT:   store_level = div_done;
         BACK_FINISH: finish      = 1'b1;
         default:     ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take_scan || finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         rsp_valid_ff <= 1'b0;
         walls_ff     <= '0;
         colors_ff    <= '0;
         red_sum_ff   <= '0;
         green_sum_ff <= '0;
         blue_sum_ff  <= '0;
         chan_ff      <= CH_RED;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (take_scan) begin
            walls_ff <= pop_cmd.walls;
         end
         if (take_pixel) begin
            red_sum_ff   <= red_add;
            green_sum_ff <= green_add;
            blue_sum_ff  <= blue_add;
         end
         if (store_level) begin
            chan_ff <= (chan_ff == CH_BLUE) ? CH_RED : chan_ff + 2'd1;
         end
         if (finish) begin
            colors_ff    <= colors_in;
            red_sum_ff   <= '0;
            green_sum_ff <= '0;
            blue_sum_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == BACK_PEAK) begin
         peak_ff <= peak_in;
      end
      if (store_level) begin
         unique case (chan_ff)
            CH_RED:   red_level_ff   <= level_value;
            CH_GREEN: green_level_ff <= level_value;
            default:  blue_level_ff  <= level_value;
         endcase
      end
      if (take_scan) begin
         rsp_kind_ff  <= KIND_SCAN;
         rsp_cell_ff  <= {colors_ff, pop_cmd.walls};
         rsp_red_ff   <= '0;
         rsp_green_ff <= '0;
         rsp_blue_ff  <= '0;
      end else if (finish) begin
         rsp_kind_ff  <= KIND_PIXEL;
         rsp_cell_ff  <= {colors_in, walls_ff};
         rsp_red_ff   <= red_level_ff;
         rsp_green_ff <= green_level_ff;
         rsp_blue_ff  <= blue_level_ff;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = rsp_kind_ff;
   assign rsp_ch.cell_res    = rsp_cell_ff;
   assign rsp_ch.red_level   = rsp_red_ff;
   assign rsp_ch.green_level = rsp_green_ff;
   assign rsp_ch.blue_level  = rsp_blue_ff;

endmodule
